FILE: rtl/core/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the cartridge bank mapper
// Holds the CPU register decode addresses, masks, the mapper state record
// and its reset value, and the decoded request and result records.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // Kind of request carried in tuser.
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_TICK  = 1'b1
  } action_e;

  // Decoded CPU register addresses (exact 16-bit match).
  localparam logic [15:0] ADDR_PRG_LO   = 16'h8000;
  localparam logic [15:0] ADDR_PRG_HI   = 16'h8001;
  localparam logic [15:0] ADDR_CHR_A    = 16'h8002;
  localparam logic [15:0] ADDR_CHR_B    = 16'h8003;
  localparam logic [15:0] ADDR_CHR_4    = 16'hA000;
  localparam logic [15:0] ADDR_CHR_5    = 16'hA001;
  localparam logic [15:0] ADDR_CHR_6    = 16'hA002;
  localparam logic [15:0] ADDR_CHR_7    = 16'hA003;
  localparam logic [15:0] ADDR_IRQ_CNT  = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_EN_A = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_EN_B = 16'hC002;
  localparam logic [15:0] ADDR_MIRROR   = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_EN_C = 16'hE001;
  localparam logic [15:0] ADDR_IRQ_EN_D = 16'hE002;

  localparam logic [7:0] OLD_PRG_MASK  = 8'h1F;
  localparam int unsigned MIRROR_BIT   = 6;
  localparam logic [8:0] LAST_IRQ_LINE = 9'd239;

  // Configuration register indexes.
  typedef enum logic {
    CFG_OLD_MODE      = 1'b0,
    CFG_IMMEDIATE_IRQ = 1'b1
  } cfg_index_e;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 72;

  // Decoded input request.
  typedef struct packed {
    action_e     action;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [8:0]  scanline;
    logic        rendering_on;
  } item_t;

  // Mapper state.
  typedef struct packed {
    logic [7:0]      prg_lo;
    logic [7:0]      prg_hi;
    logic [1:0][7:0] chr_pair;
    logic [3:0][7:0] chr_single;
    logic            mirror;
    logic [7:0]      irq_count;
    logic            irq_armed;
  } state_t;

  localparam state_t STATE_RESET = '{
    prg_lo:     8'd0,
    prg_hi:     8'd1,
    chr_pair:   {8'd1, 8'd0},
    chr_single: {8'd7, 8'd6, 8'd5, 8'd4},
    mirror:     1'b0,
    irq_count:  8'd0,
    irq_armed:  1'b0
  };

  // Configuration seen by the update logic.
  typedef struct packed {
    logic old_mode;
    logic immediate_irq;
  } cfg_t;

  // One result.
  typedef struct packed {
    logic [7:0]      prg_bank_lo;
    logic [7:0]      prg_bank_hi;
    logic [1:0][7:0] chr_pair;
    logic [3:0][7:0] chr_single;
    logic            mirror_horizontal;
    logic            irq_raise;
    logic            irq_now;
  } result_t;

endpackage

FILE: rtl/core/cbm_update.sv
// ----------------------------------------------------------------------------
// cbm_update: next-state and result logic of the bank mapper
// Applies one registered request (CPU write or scanline tick) to the current
// mapper state and forms the result from the updated state.
// ----------------------------------------------------------------------------
module cbm_update (
  input  cbm_pkg::cfg_t    cfg_i,
  input  cbm_pkg::item_t   item_i,
  input  cbm_pkg::state_t  state_i,
  output cbm_pkg::state_t  state_o,
  output cbm_pkg::result_t result_o
);

  logic [7:0] prg_val;
  logic       irq_active;
  logic       raise;
  logic       now;

  // Program bank values are cut to five bits in old mode.
  assign prg_val = cfg_i.old_mode ? (item_i.write_data & cbm_pkg::OLD_PRG_MASK)
                                  : item_i.write_data;

  // The counter only runs on visible lines with rendering on and IRQ armed.
  assign irq_active = state_i.irq_armed && item_i.rendering_on &&
                      (item_i.scanline <= cbm_pkg::LAST_IRQ_LINE);

  // Register decode and IRQ counter.
  always_comb begin
    state_o = state_i;
    raise   = 1'b0;
    now     = 1'b0;
    if (item_i.action == cbm_pkg::ACT_WRITE) begin
      case (item_i.address)
        cbm_pkg::ADDR_PRG_LO: begin
          state_o.prg_lo = prg_val;
          if (cfg_i.old_mode) begin
            state_o.mirror = item_i.write_data[cbm_pkg::MIRROR_BIT];
          end
        end
        cbm_pkg::ADDR_PRG_HI:  state_o.prg_hi        = prg_val;
        cbm_pkg::ADDR_CHR_A:   state_o.chr_pair[0]   = item_i.write_data;
        cbm_pkg::ADDR_CHR_B:   state_o.chr_pair[1]   = item_i.write_data;
        cbm_pkg::ADDR_CHR_4:   state_o.chr_single[0] = item_i.write_data;
        cbm_pkg::ADDR_CHR_5:   state_o.chr_single[1] = item_i.write_data;
        cbm_pkg::ADDR_CHR_6:   state_o.chr_single[2] = item_i.write_data;
        cbm_pkg::ADDR_CHR_7:   state_o.chr_single[3] = item_i.write_data;
        cbm_pkg::ADDR_IRQ_CNT: state_o.irq_count     = item_i.write_data;
        cbm_pkg::ADDR_IRQ_EN_A,
        cbm_pkg::ADDR_IRQ_EN_B,
        cbm_pkg::ADDR_IRQ_EN_C,
        cbm_pkg::ADDR_IRQ_EN_D: begin
          state_o.irq_armed = (item_i.write_data != 8'd0);
        end
        cbm_pkg::ADDR_MIRROR: begin
          state_o.mirror = item_i.write_data[cbm_pkg::MIRROR_BIT];
        end
        default: begin
        end
      endcase
    end else if (irq_active) begin
      if (state_i.irq_count == 8'd0) begin
        raise             = 1'b1;
        now               = cfg_i.immediate_irq;
        state_o.irq_armed = 1'b0;
      end else begin
        state_o.irq_count = state_i.irq_count + 8'd1;
      end
    end
  end

  // The result reports the state after the update.
  assign result_o.prg_bank_lo       = state_o.prg_lo;
  assign result_o.prg_bank_hi       = state_o.prg_hi;
  assign result_o.chr_pair          = state_o.chr_pair;
  assign result_o.chr_single        = state_o.chr_single;
  assign result_o.mirror_horizontal = state_o.mirror;
  assign result_o.irq_raise         = raise;
  assign result_o.irq_now           = now;

endmodule

FILE: rtl/core/cartridge_bank_mapper_irq_top.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_top: cartridge bank mapper with scanline IRQ
// Input register, update logic and result register around the mapper state.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel. tuser selects the kind: 0 is a CPU
//   register write (address and write_data used), 1 is a scanline tick
//   (scanline and rendering_on used). Each request yields exactly one result
//   on the m_axis channel with the full bank map, the mirroring and the IRQ
//   flags, all taken after the request has been applied.
//   A taken request sits in the input register, is applied by the
//   combinational update logic and moves into the result register, which
//   drives m_axis_tvalid, when that register is free or being drained.
//   Throughput is one request per cycle while results are taken without a
//   stall. The pipeline holds up to two requests. While m_axis_tready is low
//   with a result waiting, the input register still takes one more request;
//   once both registers are full, s_axis_tready follows m_axis_tready in the
//   same cycle. Configuration (old_mode, immediate_irq) is to be written by
//   the user through cfg_we_i while the block is idle; the block does not
//   enforce this. It takes effect for the following requests.
//   Reset clears the pipeline and loads the power-on bank map: program
//   banks 0 and 1, pattern pairs 0 and 1, singles 4 to 7, vertical
//   mirroring, IRQ counter 0 and disarmed.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: address[15:0], write_data[23:16], scanline[32:24],
  //        rendering_on[33], zero fill[39:34]
  input  logic [cbm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: action[0]
  input  logic                           s_axis_tuser,
  // Result channel.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: prg_bank_lo[7:0], prg_bank_hi[15:8], chr_pair_a[23:16],
  //        chr_pair_b[31:24], chr_single_4[39:32], chr_single_5[47:40],
  //        chr_single_6[55:48], chr_single_7[63:56], mirror_horizontal[64],
  //        irq_raise[65], irq_now[66], zero fill[71:67]
  output logic [cbm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic                           cfg_data_i
);

  logic              item_valid_q;
  cbm_pkg::item_t    item_q;
  logic              res_valid_q;
  cbm_pkg::result_t  res_q;
  cbm_pkg::state_t   state_q;
  cbm_pkg::state_t   state_d;
  cbm_pkg::result_t  res_d;
  cbm_pkg::cfg_t     cfg_q;
  logic              advance;
  logic              in_fire;

  // Pipeline moves when the result register is free or being drained.
  assign advance       = !res_valid_q || m_axis_tready;
  assign s_axis_tready = !item_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cbm_pkg::cfg_index_e'(cfg_index_i))
        cbm_pkg::CFG_OLD_MODE:      cfg_q.old_mode      <= cfg_data_i;
        cbm_pkg::CFG_IMMEDIATE_IRQ: cfg_q.immediate_irq <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.action       <= cbm_pkg::action_e'(s_axis_tuser);
      item_q.address      <= s_axis_tdata[15:0];
      item_q.write_data   <= s_axis_tdata[23:16];
      item_q.scanline     <= s_axis_tdata[32:24];
      item_q.rendering_on <= s_axis_tdata[33];
    end
  end

  cbm_update u_update (
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Mapper state is committed when the request moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbm_pkg::STATE_RESET;
    end else if (advance && item_valid_q) begin
      state_q <= state_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= item_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance && item_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {5'd0, res_q.irq_now, res_q.irq_raise,
                          res_q.mirror_horizontal,
                          res_q.chr_single[3], res_q.chr_single[2],
                          res_q.chr_single[1], res_q.chr_single[0],
                          res_q.chr_pair[1], res_q.chr_pair[0],
                          res_q.prg_bank_hi, res_q.prg_bank_lo};

  // A raised IRQ always disarms the counter.
  a_raise_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_valid_q && res_d.irq_raise) |=> !state_q.irq_armed)
    else $error("IRQ raised but counter still armed");

  // The mapper state only changes when a request is committed.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && item_valid_q) |=> $stable(state_q))
    else $error("mapper state changed without a committed request");

  // CPU writes never report an IRQ.
  a_write_no_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_valid_q && item_q.action == cbm_pkg::ACT_WRITE)
    |=> (!res_q.irq_raise && !res_q.irq_now))
    else $error("IRQ flags set on a CPU write result");

  // The immediate flag is only set together with a raise.
  a_now_needs_raise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.irq_now) |-> res_q.irq_raise)
    else $error("irq_now set without irq_raise");

endmodule

FILE: verif/cartridge_bank_mapper_irq_top_tb.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_top_tb: self-checking bench for the bank mapper
// Drives CPU register writes and scanline ticks into the request stream and
// predicts the bank map, mirroring and IRQ flags of every result. A short
// directed table comes first, then random traffic under several mapper
// settings, with random gaps on both streams and one long result stall.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq_top_tb;
  import cbm_pkg::*;

  // Result fields as the bench sees them; chr[0..1] are the pairs and
  // chr[2..5] the single 1 KB slots 4 to 7.
  typedef struct packed {
    logic [7:0]      prg_lo;
    logic [7:0]      prg_hi;
    logic [5:0][7:0] chr;
    logic            mirror;
    logic            raise;
    logic            now;
  } map_view_t;

  typedef enum logic {
    ROW_REQUEST = 1'b0,
    ROW_CONFIG  = 1'b1
  } row_kind_e;

  // One row of the directed stimulus.
  typedef struct packed {
    row_kind_e   kind;
    action_e     act;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  line;
    logic        render;
    logic        cfg_old;
    logic        cfg_imm;
    logic        typed;
    map_view_t   want;
  } dir_row_t;

  localparam logic [5:0][7:0] RESET_CHR = {8'd7, 8'd6, 8'd5, 8'd4, 8'd1, 8'd0};
  localparam map_view_t NO_MAP = '0;
  localparam map_view_t RESET_MAP = '{prg_lo: 8'h00, prg_hi: 8'h01, chr: RESET_CHR,
                                      mirror: 1'b0, raise: 1'b0, now: 1'b0};
  localparam map_view_t MAP_PRG_LO_FF = '{prg_lo: 8'hFF, prg_hi: 8'h01, chr: RESET_CHR,
                                          mirror: 1'b0, raise: 1'b0, now: 1'b0};
  localparam map_view_t MAP_PRG_FF_00 = '{prg_lo: 8'hFF, prg_hi: 8'h00, chr: RESET_CHR,
                                          mirror: 1'b0, raise: 1'b0, now: 1'b0};

  localparam int DIRECTED_COUNT = 31;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 254;
  localparam int PRESSURE_AFTER = 200;
  localparam int PRESSURE_CYCLES = 80;
  localparam int MAX_REPORTS = 40;

  localparam dir_row_t DIRECTED_ROWS[DIRECTED_COUNT] = '{
    // Power-on map through an undecoded write and a disarmed tick.
    '{ROW_REQUEST, ACT_WRITE, 16'h0000, 8'h00, 9'd0,   1'b0, 1'b0, 1'b0, 1'b1, RESET_MAP},
    '{ROW_REQUEST, ACT_TICK,  16'h0000, 8'h00, 9'd0,   1'b1, 1'b0, 1'b0, 1'b1, RESET_MAP},
    // Program banks at their extremes.
    '{ROW_REQUEST, ACT_WRITE, 16'h8000, 8'hFF, 9'd0,   1'b0, 1'b0, 1'b0, 1'b1, MAP_PRG_LO_FF},
    '{ROW_REQUEST, ACT_WRITE, 16'h8001, 8'h00, 9'd0,   1'b0, 1'b0, 1'b0, 1'b1, MAP_PRG_FF_00},
    // Pattern banks and mirroring.
    '{ROW_REQUEST, ACT_WRITE, 16'h8002, 8'hFF, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'h8003, 8'h80, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'hA000, 8'h01, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'hA001, 8'hFE, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'hA002, 8'h55, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'hA003, 8'hAA, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'hE000, 8'h40, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'hE000, 8'hBF, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    // Zero counter, armed: blocked ticks, then a pending IRQ, then disarmed.
    '{ROW_REQUEST, ACT_WRITE, 16'hC000, 8'h00, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'hC001, 8'h01, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_TICK,  16'h0000, 8'h00, 9'd240, 1'b1, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_TICK,  16'h0000, 8'h00, 9'd239, 1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_TICK,  16'h0000, 8'h00, 9'd239, 1'b1, 1'b0, 1'b0, 1'b0, NO_MAP},
    // Counter wraps from 0xFF to zero, then raises.
    '{ROW_REQUEST, ACT_WRITE, 16'hE002, 8'hFF, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'hC000, 8'hFE, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_TICK,  16'hFFFF, 8'hFF, 9'd100, 1'b1, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_TICK,  16'h0000, 8'h00, 9'd0,   1'b1, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_TICK,  16'h0000, 8'h00, 9'd5,   1'b1, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'hC002, 8'h00, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'hFFFF, 8'hFF, 9'd511, 1'b1, 1'b0, 1'b0, 1'b0, NO_MAP},
    // Old mode with immediate IRQ: masked program banks, mirroring via 0x8000.
    '{ROW_CONFIG,  ACT_WRITE, 16'h0000, 8'h00, 9'd0,   1'b0, 1'b1, 1'b1, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'h8000, 8'hFF, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'h8001, 8'hE0, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'hE001, 8'h01, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_TICK,  16'h0000, 8'h00, 9'd239, 1'b1, 1'b0, 1'b0, 1'b0, NO_MAP},
    // Leaving old mode keeps the stored banks.
    '{ROW_CONFIG,  ACT_WRITE, 16'h0000, 8'h00, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP},
    '{ROW_REQUEST, ACT_WRITE, 16'h8001, 8'hFF, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, NO_MAP}
  };

  localparam logic [15:0] DECODED_ADDRS[14] = '{
    ADDR_PRG_LO, ADDR_PRG_HI, ADDR_CHR_A, ADDR_CHR_B, ADDR_CHR_4, ADDR_CHR_5,
    ADDR_CHR_6, ADDR_CHR_7, ADDR_IRQ_CNT, ADDR_IRQ_EN_A, ADDR_IRQ_EN_B,
    ADDR_MIRROR, ADDR_IRQ_EN_C, ADDR_IRQ_EN_D
  };
  localparam logic [15:0] ARM_ADDRS[4] = '{
    ADDR_IRQ_EN_A, ADDR_IRQ_EN_B, ADDR_IRQ_EN_C, ADDR_IRQ_EN_D
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_index_i = 1'b0;
  logic                  cfg_data_i = 1'b0;

  // Predicted mapper state and settings.
  logic [7:0]      prg_lo_q = 8'h00;
  logic [7:0]      prg_hi_q = 8'h01;
  logic [5:0][7:0] chr_q = RESET_CHR;
  logic            mirror_q = 1'b0;
  logic [7:0]      irq_count_q = 8'h00;
  logic            irq_armed_q = 1'b0;
  logic            old_mode_q = 1'b0;
  logic            immediate_q = 1'b0;

  map_view_t pending_maps[$];

  int error_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int irq_raise_count = 0;
  int settings_applied = 0;
  bit sender_quiet = 1'b0;
  bit receiver_quiet = 1'b0;
  bit pressure_done = 1'b0;
  int stall_left = 0;

  cartridge_bank_mapper_irq_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock with a period of four time units.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Applies one request to the predicted state and returns the map after it.
  function automatic map_view_t predict_bank_map(action_e act, logic [15:0] addr,
                                                 logic [7:0] data, logic [8:0] line,
                                                 logic render);
    logic [7:0] prg_val;
    map_view_t  view;
    prg_val = old_mode_q ? (data & OLD_PRG_MASK) : data;
    view.raise = 1'b0;
    view.now = 1'b0;
    if (act == ACT_WRITE) begin
      case (addr)
        ADDR_PRG_LO: begin
          if (old_mode_q) mirror_q = data[MIRROR_BIT];
          prg_lo_q = prg_val;
        end
        ADDR_PRG_HI: prg_hi_q = prg_val;
        ADDR_CHR_A: chr_q[0] = data;
        ADDR_CHR_B: chr_q[1] = data;
        ADDR_CHR_4: chr_q[2] = data;
        ADDR_CHR_5: chr_q[3] = data;
        ADDR_CHR_6: chr_q[4] = data;
        ADDR_CHR_7: chr_q[5] = data;
        ADDR_IRQ_CNT: irq_count_q = data;
        ADDR_IRQ_EN_A, ADDR_IRQ_EN_B, ADDR_IRQ_EN_C, ADDR_IRQ_EN_D:
          irq_armed_q = (data != 8'h00);
        ADDR_MIRROR: mirror_q = data[MIRROR_BIT];
        default: ;
      endcase
    end else if (irq_armed_q && render && line <= LAST_IRQ_LINE) begin
      // A zero counter fires and disarms; anything else counts up.
      if (irq_count_q == 8'h00) begin
        view.raise = 1'b1;
        view.now = immediate_q;
        irq_armed_q = 1'b0;
      end else begin
        irq_count_q = irq_count_q + 8'h01;
      end
    end
    view.prg_lo = prg_lo_q;
    view.prg_hi = prg_hi_q;
    view.chr = chr_q;
    view.mirror = mirror_q;
    return view;
  endfunction

  // Gap before the next request: mostly none or short, a few long.
  function automatic int pick_gap();
    int roll;
    if (sender_quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Offers one request, waits for it to be taken and records its result.
  task automatic issue_request(action_e act, logic [15:0] addr, logic [7:0] data,
                               logic [8:0] line, logic render, logic typed,
                               map_view_t typed_map);
    int        gap;
    map_view_t predicted;
    if ($urandom_range(0, 99) == 0) sender_quiet = !sender_quiet;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {6'b0, render, line, data, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_bank_map(act, addr, data, line, render);
    pending_maps.push_back(typed ? typed_map : predicted);
    if (predicted.raise) irq_raise_count++;
    requests_sent++;
  endtask

  // Scanline tick, mostly on visible lines with rendering on.
  task automatic issue_tick();
    logic [8:0] line;
    line = ($urandom_range(0, 9) < 8) ? 9'($urandom_range(0, 239))
                                      : 9'($urandom_range(0, 511));
    issue_request(ACT_TICK, 16'($urandom), 8'($urandom), line,
                  1'($urandom_range(0, 7) != 0), 1'b0, NO_MAP);
  endtask

  // Waits until every predicted result has arrived and the pipeline is empty.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes both mapper settings while the block is idle.
  task automatic apply_config(logic old_mode, logic immediate);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_OLD_MODE;
    cfg_data_i <= old_mode;
    @(posedge clk_i);
    cfg_index_i <= CFG_IMMEDIATE_IRQ;
    cfg_data_i <= immediate;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    old_mode_q = old_mode;
    immediate_q = immediate;
    settings_applied++;
  endtask

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Compares one accepted result against the oldest prediction.
  task automatic check_result(logic [OUT_DATA_W-1:0] tdata);
    map_view_t want;
    if (pending_maps.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: result with no request pending: expected none, got %0h",
                 $time, tdata);
      return;
    end
    want = pending_maps.pop_front();
    compare_field("prg_bank_lo", want.prg_lo, tdata[7:0]);
    compare_field("prg_bank_hi", want.prg_hi, tdata[15:8]);
    for (int k = 0; k < 6; k++)
      compare_field($sformatf("chr bank slot group %0d", k), want.chr[k],
                    tdata[16 + 8 * k +: 8]);
    compare_field("mirror_horizontal", 8'(want.mirror), 8'(tdata[64]));
    compare_field("irq_raise", 8'(want.raise), 8'(tdata[65]));
    compare_field("irq_now", 8'(want.now), 8'(tdata[66]));
    results_checked++;
  endtask

  // Result side: check what was taken, then decide readiness for next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    if ($urandom_range(0, 199) == 0) receiver_quiet = !receiver_quiet;
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!pressure_done && results_checked >= PRESSURE_AFTER) begin
      // One long hold-off so the pipeline fills and backs up the requests.
      pressure_done = 1'b1;
      stall_left = PRESSURE_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (!receiver_quiet && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                              : $urandom_range(3, 30);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Stimulus: reset, directed table, then random phases under each setting.
  initial begin
    dir_row_t    row;
    int          phase_end;
    int          k;
    logic [15:0] addr;
    logic [7:0]  data;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_CONFIG) apply_config(row.cfg_old, row.cfg_imm);
      else issue_request(row.act, row.addr, row.data, row.line, row.render,
                         row.typed, row.want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_config(1'b0, 1'b0);
        1: apply_config(1'b1, 1'b1);
        2: apply_config(1'b1, 1'b0);
        3: apply_config(1'b0, 1'b1);
        default: apply_config(1'($urandom), 1'($urandom));
      endcase
      phase_end = requests_sent + ITEMS_PER_PHASE;
      while (requests_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) begin
          // Well-formed IRQ setup: counter near wrap, arm, then enough ticks.
          k = $urandom_range(0, 5);
          issue_request(ACT_WRITE, ADDR_IRQ_CNT, 8'(256 - k), 9'($urandom),
                        1'($urandom), 1'b0, NO_MAP);
          issue_request(ACT_WRITE, ARM_ADDRS[$urandom_range(0, 3)],
                        8'($urandom_range(1, 255)), 9'($urandom), 1'($urandom),
                        1'b0, NO_MAP);
          repeat (k + 2) issue_tick();
        end else if ($urandom_range(0, 99) < 45) begin
          issue_tick();
        end else begin
          // Register write: mostly decoded addresses, some arbitrary ones.
          addr = ($urandom_range(0, 99) < 85) ? DECODED_ADDRS[$urandom_range(0, 13)]
                                              : 16'($urandom);
          data = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
          issue_request(ACT_WRITE, addr, data, 9'($urandom), 1'($urandom),
                        1'b0, NO_MAP);
        end
      end
    end

    wait_idle();
    $display("Sent %0d requests (%0d directed rows) under %0d mapper settings.",
             requests_sent, DIRECTED_COUNT, settings_applied);
    $display("Checked %0d results, %0d of them raising an IRQ.",
             results_checked, irq_raise_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Timeout with %0d results still pending.", pending_maps.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
